FILE: rtl/rpsc_pkg.sv
`timescale 1ns / 1ps

package rpsc_pkg;

  localparam int T_W      = 25;  // time_ms
  localparam int S_W      = 14;  // sensor_temp, signed
  localparam int TGT_W    = 13;  // target_temp
  localparam int PWM_W    = 4;
  localparam int DEG_W    = 9;   // whole degrees
  localparam int SEC_W    = 12;  // phase duration in seconds
  localparam int DUR_W    = 22;  // phase duration in milliseconds
  localparam int CUM_W    = 26;  // running sum of durations
  localparam int FIELD_W  = 21;  // one packed phase
  localparam int PAIR_W   = 42;  // two packed phases
  localparam int PAIRS    = 4;
  localparam int CFG_IDX_W = 3;

  localparam int P1_W     = 35;  // start * 16 * duration
  localparam int NUM_W    = 37;  // signed numerator
  localparam int DIV_STEPS = 13; // one quotient bit per step
  localparam int DIVC_W   = 4;

  localparam logic [DEG_W-1:0] START_DEG = 9'd20;
  localparam logic [9:0]       MS_PER_S  = 10'd1000;
  localparam logic signed [S_W:0] BAND_16THS = 15'sd32;
  localparam logic [PWM_W-1:0] PWM_HEAT  = 4'd15;
  localparam logic [PWM_W-1:0] PWM_OFF   = 4'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_CONST = 3'd1,
    REG_COUNT = 3'd2,
    REG_PAIR0 = 3'd3,
    REG_PAIR1 = 3'd4,
    REG_PAIR2 = 3'd5,
    REG_PAIR3 = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                          mode;
    logic [DEG_W-1:0]              const_target;
    logic [3:0]                    phase_count;
    logic [PAIRS-1:0][PAIR_W-1:0]  pairs;
  } cfg_t;

  typedef struct packed {
    logic       load;      // capture the input item and clear the scan state
    logic       scan;      // evaluate one phase
    logic [2:0] phase;     // phase under evaluation
    logic       mul;       // form the two products
    logic       div_init;  // sum the products and seed the divider
    logic       div_step;  // one restoring divide step
    logic       out_load;  // latch the result item
  } dp_cmd_t;

  typedef struct packed {
    logic found;           // the time fell inside one of the phases
  } dp_status_t;

endpackage

FILE: rtl/rpsc_in_if.sv
`timescale 1ns / 1ps

interface rpsc_in_if
  import rpsc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [T_W-1:0]        time_ms;
  logic signed [S_W-1:0] sensor_temp;

  modport source (output valid, output time_ms, output sensor_temp, input ready);
  modport sink   (input valid, input time_ms, input sensor_temp, output ready);
endinterface

FILE: rtl/rpsc_out_if.sv
`timescale 1ns / 1ps

interface rpsc_out_if
  import rpsc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [TGT_W-1:0] target_temp;
  logic [PWM_W-1:0] pwm_percent;
  logic             cooling_on;
  logic             relay_on;

  modport source (output valid, output target_temp, output pwm_percent,
                  output cooling_on, output relay_on, input ready);
  modport sink   (input valid, input target_temp, input pwm_percent,
                  input cooling_on, input relay_on, output ready);
endinterface

FILE: rtl/reflow_profile_setpoint_controller.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// in_if     in   valid/ready   time_ms[24:0], sensor_temp[13:0] signed
// out_if    out  valid/ready   target_temp[12:0], pwm_percent[3:0], cooling_on, relay_on
// cfg       in   cfg_we_i      cfg_idx_i[2:0], cfg_data_i[41:0]
//
// One item is processed at a time. Constant mode or no phases: the item goes from idle
// to the final state, where the result is registered once the output register is free.
// Ramping mode scans the phases (one phase per cycle) and checks for a hit; outside every
// phase it goes to the final state, inside one through the sum state and the restoring
// divider (one quotient bit per cycle). The next item is taken once back in idle.
// Reset clears the control state and the found flag and restores the config defaults.
// A result waits in the output register; the next item is accepted meanwhile and its
// result is held back until that register is taken.

module reflow_profile_setpoint_controller
  import rpsc_pkg::*;
#(
  parameter int MAX_PHASES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rpsc_in_if.sink              in_if,
  rpsc_out_if.source           out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PAIR_W-1:0]    cfg_data_i
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  rpsc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  rpsc_ctrl #(
    .MAX_PHASES (MAX_PHASES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (cfg.mode),
    .phase_count_i (cfg.phase_count),
    .in_valid_i    (in_if.valid),
    .in_ready_o    (in_if.ready),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  rpsc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .time_ms_i     (in_if.time_ms),
    .sensor_temp_i (in_if.sensor_temp),
    .target_temp_o (out_if.target_temp),
    .pwm_percent_o (out_if.pwm_percent),
    .cooling_on_o  (out_if.cooling_on),
    .relay_on_o    (out_if.relay_on)
  );

`ifndef SYNTHESIS
  // Only one item is in flight, so taking an item drops ready on the next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("item accepted while another is in flight");

  // Heater drive and cooling are always opposite.
  a_heat_cool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ((out_if.pwm_percent == PWM_HEAT && !out_if.cooling_on) ||
                      (out_if.pwm_percent == PWM_OFF && out_if.cooling_on)))
    else $error("pwm and cooling disagree");

  // The target never exceeds 511 whole degrees, counted in sixteenths of a degree.
  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.target_temp <= 13'd8176))
    else $error("target outside the degree range");
`endif

endmodule

FILE: rtl/rpsc_cfg.sv
`timescale 1ns / 1ps

module rpsc_cfg
  import rpsc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [PAIR_W-1:0]    data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= 1'b1;
      cfg_q.const_target <= START_DEG;
      cfg_q.phase_count  <= 4'd0;
      cfg_q.pairs        <= '0;
    end else if (we_i) begin
      case (cfg_idx_e'(idx_i))
        REG_MODE:  cfg_q.mode         <= data_i[0];
        REG_CONST: cfg_q.const_target <= data_i[DEG_W-1:0];
        REG_COUNT: cfg_q.phase_count  <= data_i[3:0];
        REG_PAIR0: cfg_q.pairs[0]     <= data_i;
        REG_PAIR1: cfg_q.pairs[1]     <= data_i;
        REG_PAIR2: cfg_q.pairs[2]     <= data_i;
        REG_PAIR3: cfg_q.pairs[3]     <= data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/rpsc_ctrl.sv
`timescale 1ns / 1ps

module rpsc_ctrl
  import rpsc_pkg::*;
#(
  parameter int MAX_PHASES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_i,
  input  logic [3:0] phase_count_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int CNT_W = $clog2(MAX_PHASES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    k_q;
  logic [DIVC_W-1:0]   div_cnt_q;
  logic                out_valid_q;
  logic [CNT_W-1:0]    n_phases;
  logic                in_acc;
  logic                slot_free;

  assign n_phases  = (phase_count_i > MAX_PHASES) ? CNT_W'(MAX_PHASES)
                                                  : CNT_W'(phase_count_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_acc;
    cmd_o.scan     = (state_q == ST_SCAN);
    cmd_o.phase    = 3'(k_q);
    cmd_o.mul      = (state_q == ST_CHECK) && status_i.found;
    cmd_o.div_init = (state_q == ST_SUM);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.out_load = (state_q == ST_FIN) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          if (in_valid_i) begin
            if (!mode_i || (n_phases == '0)) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          k_q <= CNT_W'(k_q + 1'b1);
          if (CNT_W'(k_q + 1'b1) == n_phases) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_q <= status_i.found ? ST_SUM : ST_FIN;
        end
        ST_SUM: begin
          div_cnt_q <= '0;
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= DIVC_W'(div_cnt_q + 1'b1);
          if (div_cnt_q == DIVC_W'(DIV_STEPS - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/rpsc_dp.sv
`timescale 1ns / 1ps

module rpsc_dp
  import rpsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic [T_W-1:0]        time_ms_i,
  input  logic signed [S_W-1:0] sensor_temp_i,
  output logic [TGT_W-1:0]      target_temp_o,
  output logic [PWM_W-1:0]      pwm_percent_o,
  output logic                  cooling_on_o,
  output logic                  relay_on_o
);

  logic [T_W-1:0]          t_q;
  logic signed [S_W-1:0]   sensor_q;
  logic [CUM_W-1:0]        cum_q;
  logic [DEG_W-1:0]        start_q;
  logic                    found_q;
  logic [DEG_W-1:0]        h_start_q;
  logic [DEG_W-1:0]        h_end_q;
  logic [DUR_W-1:0]        h_dur_q;
  logic [DUR_W-1:0]        off_q;
  logic [P1_W-1:0]         p1_q;
  logic signed [NUM_W-1:0] p2_q;
  logic [DUR_W-1:0]        rem_q;
  logic [TGT_W-1:0]        quo_q;
  logic [TGT_W-1:0]        tgt_out_q;
  logic [PWM_W-1:0]        pwm_out_q;
  logic                    cool_out_q;
  logic                    relay_out_q;

  logic [PAIR_W-1:0]       pair;
  logic [FIELD_W-1:0]      fld;
  logic [DEG_W-1:0]        f_end;
  logic [SEC_W-1:0]        f_sec;
  logic [DUR_W-1:0]        f_dur;
  logic [CUM_W-1:0]        t_ext;
  logic [CUM_W-1:0]        cum_end;
  logic                    hit;
  logic [30:0]             sd;
  logic signed [9:0]       delta;
  logic signed [13:0]      delta16;
  logic signed [NUM_W-1:0] p2_d;
  logic signed [NUM_W-1:0] num;
  logic [DUR_W:0]          trial;
  logic                    ge;
  logic [TGT_W-1:0]        target;
  logic                    heat;
  logic                    relay;

  // Phase currently selected by the scan.
  assign pair    = cfg_i.pairs[cmd_i.phase[2:1]];
  assign fld     = cmd_i.phase[0] ? pair[PAIR_W-1:FIELD_W] : pair[FIELD_W-1:0];
  assign f_end   = fld[DEG_W-1:0];
  assign f_sec   = fld[FIELD_W-1:DEG_W];
  assign f_dur   = DUR_W'({10'b0, f_sec} * {12'b0, MS_PER_S});
  assign t_ext   = {{(CUM_W-T_W){1'b0}}, t_q};
  assign cum_end = cum_q + {{(CUM_W-DUR_W){1'b0}}, f_dur};
  assign hit     = !found_q && (t_ext > cum_q) && (t_ext <= cum_end);

  // Interpolation products; the numerator is never negative inside a phase.
  assign sd      = 31'(h_start_q) * 31'(h_dur_q);
  assign delta   = $signed({1'b0, h_end_q}) - $signed({1'b0, h_start_q});
  assign delta16 = {delta, 4'b0};
  assign p2_d    = $signed({{(NUM_W-DUR_W){1'b0}}, off_q})
                 * $signed({{(NUM_W-14){delta16[13]}}, delta16});
  assign num     = $signed({2'b0, p1_q}) + p2_q;

  // The quotient stays below 2^13, so the upper numerator bits seed the remainder.
  assign trial   = {rem_q, quo_q[TGT_W-1]};
  assign ge      = trial >= {1'b0, h_dur_q};

  always_comb begin
    if (!cfg_i.mode) begin
      target = {cfg_i.const_target, 4'b0};
    end else if (found_q) begin
      target = quo_q;
    end else begin
      target = {start_q, 4'b0};
    end
  end

  assign heat  = $signed({2'b0, target}) > ($signed({sensor_q[S_W-1], sensor_q}) + BAND_16THS);
  assign relay = !cfg_i.mode || ((t_q != '0) && (t_ext < cum_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan && hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q      <= time_ms_i;
      sensor_q <= sensor_temp_i;
      cum_q    <= '0;
      start_q  <= START_DEG;
    end
    if (cmd_i.scan) begin
      cum_q   <= cum_end;
      start_q <= f_end;
      if (hit) begin
        h_start_q <= start_q;
        h_end_q   <= f_end;
        h_dur_q   <= f_dur;
        off_q     <= DUR_W'(t_ext - cum_q);
      end
    end
    if (cmd_i.mul) begin
      p1_q <= {sd, 4'b0};
      p2_q <= p2_d;
    end
    if (cmd_i.div_init) begin
      rem_q <= num[P1_W-1:TGT_W];
      quo_q <= num[TGT_W-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? DUR_W'(trial - {1'b0, h_dur_q}) : trial[DUR_W-1:0];
      quo_q <= {quo_q[TGT_W-2:0], ge};
    end
    if (cmd_i.out_load) begin
      tgt_out_q   <= target;
      pwm_out_q   <= heat ? PWM_HEAT : PWM_OFF;
      cool_out_q  <= !heat;
      relay_out_q <= relay;
    end
  end

  assign status_o.found = found_q;
  assign target_temp_o  = tgt_out_q;
  assign pwm_percent_o  = pwm_out_q;
  assign cooling_on_o   = cool_out_q;
  assign relay_on_o     = relay_out_q;

endmodule

FILE: sim/tb_reflow_profile_setpoint_controller.sv
`timescale 1ns / 1ps

module tb_reflow_profile_setpoint_controller;
  import rpsc_pkg::*;

  localparam int PHASE_MAX = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [T_W-1:0] T_MAX = '1;

  typedef struct {
    logic [T_W-1:0]        time_ms;
    logic signed [S_W-1:0] sensor_temp;
  } reading_t;

  typedef struct packed {
    logic [TGT_W-1:0] target_temp;
    logic [PWM_W-1:0] pwm_percent;
    logic             cooling_on;
    logic             relay_on;
  } setpoint_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  src_valid = 1'b0;
  logic [T_W-1:0]        src_time = '0;
  logic signed [S_W-1:0] src_sensor = '0;
  logic                  sink_ready = 1'b0;
  logic                  sink_hold = 1'b0;
  logic                  hold_request = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [PAIR_W-1:0]    cfg_data = '0;

  reading_t  pending_readings[$];
  setpoint_t expected_setpoints[$];
  cfg_t      shadow_cfg;

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int readings_sent = 0;
  int results_checked = 0;
  int heat_results = 0;
  int relay_results = 0;
  int settings_applied = 0;
  int watchdog_cycles;
  int hold_cycles;

  rpsc_in_if  in_ch ();
  rpsc_out_if out_ch ();

  assign in_ch.valid       = src_valid;
  assign in_ch.time_ms     = src_time;
  assign in_ch.sensor_temp = src_sensor;
  assign out_ch.ready      = sink_ready;

  reflow_profile_setpoint_controller #(
    .MAX_PHASES(PHASE_MAX)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [FIELD_W-1:0] phase_of(input cfg_t c, input int k);
    return c.pairs[k / 2][(k % 2) * FIELD_W +: FIELD_W];
  endfunction

  function automatic logic [FIELD_W-1:0] phase_bits(input logic [DEG_W-1:0] deg,
                                                    input logic [SEC_W-1:0] sec);
    return {sec, deg};
  endfunction

  function automatic int active_phases(input cfg_t c);
    return (c.phase_count > PHASE_MAX) ? PHASE_MAX : int'(c.phase_count);
  endfunction

  // Target along the piecewise linear profile, then the bang-bang decision.
  function automatic setpoint_t predict_setpoint(input cfg_t c, input logic [T_W-1:0] t,
                                                 input logic signed [S_W-1:0] s);
    setpoint_t r;
    int k;
    longint span_ms, from_ms, num;
    logic [DEG_W-1:0] from_deg, to_deg;
    logic [FIELD_W-1:0] f;
    logic hit;
    logic [TGT_W-1:0] tgt;
    r = '0;
    if (!c.mode) begin
      tgt = {c.const_target, 4'd0};
      r.relay_on = 1'b1;
    end else begin
      from_ms = 0;
      from_deg = START_DEG;
      hit = 1'b0;
      tgt = '0;
      for (k = 0; k < active_phases(c); k++) begin
        f = phase_of(c, k);
        to_deg = f[DEG_W-1:0];
        span_ms = longint'(f[FIELD_W-1:DEG_W]) * 1000;
        // A phase owns the times just after its start up to and including its end.
        if (!hit && longint'(t) > from_ms && longint'(t) <= from_ms + span_ms) begin
          num = longint'(from_deg) * 16 * span_ms
              + (longint'(t) - from_ms) * (longint'(to_deg) - longint'(from_deg)) * 16;
          tgt = TGT_W'(num / span_ms);
          hit = 1'b1;
        end
        from_ms += span_ms;
        from_deg = to_deg;
      end
      if (!hit) tgt = {from_deg, 4'd0};
      r.relay_on = (t != '0) && (longint'(t) < from_ms);
    end
    r.target_temp = tgt;
    if (int'(tgt) > int'(s) + int'(BAND_16THS)) begin
      r.pwm_percent = PWM_HEAT;
      r.cooling_on = 1'b0;
    end else begin
      r.pwm_percent = PWM_OFF;
      r.cooling_on = 1'b1;
    end
    return r;
  endfunction

  // Times cluster inside the profile and on the phase boundaries.
  function automatic logic [T_W-1:0] pick_time(input cfg_t c);
    longint bound_ms[PHASE_MAX+1];
    int n, k, roll;
    longint t;
    logic [FIELD_W-1:0] f;
    n = active_phases(c);
    bound_ms[0] = 0;
    for (k = 0; k < n; k++) begin
      f = phase_of(c, k);
      bound_ms[k+1] = bound_ms[k] + longint'(f[FIELD_W-1:DEG_W]) * 1000;
    end
    roll = $urandom_range(99);
    if (roll < 10) begin
      t = longint'($urandom_range(int'(T_MAX)));
    end else if (roll < 35) begin
      t = bound_ms[$urandom_range(n)] + longint'($urandom_range(2)) - 1;
      if (t < 0) t = 0;
      if (t > longint'(T_MAX)) t = longint'(T_MAX);
    end else begin
      t = longint'($urandom_range(int'(bound_ms[n]) + 1000));
    end
    return t[T_W-1:0];
  endfunction

  // Half of the sensor values sit right at the heat/cool threshold.
  function automatic logic signed [S_W-1:0] pick_sensor(input logic [TGT_W-1:0] tgt);
    int roll, s;
    roll = $urandom_range(99);
    if (roll < 50) s = int'(tgt) - int'(BAND_16THS) + int'($urandom_range(8)) - 4;
    else if (roll < 90) s = int'($urandom_range(8991)) - 800;
    else s = int'($urandom_range(16383)) - 8192;
    return s[S_W-1:0];
  endfunction

  task automatic queue_reading(input logic [T_W-1:0] t, input logic signed [S_W-1:0] s);
    reading_t rd;
    rd.time_ms = t;
    rd.sensor_temp = s;
    pending_readings.push_back(rd);
  endtask

  task automatic queue_near_threshold(input logic [T_W-1:0] t);
    setpoint_t guess;
    guess = predict_setpoint(shadow_cfg, t, '0);
    queue_reading(t, pick_sensor(guess.target_temp));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      REG_MODE:  shadow_cfg.mode = data[0];
      REG_CONST: shadow_cfg.const_target = data[DEG_W-1:0];
      REG_COUNT: shadow_cfg.phase_count = data[3:0];
      REG_PAIR0, REG_PAIR1, REG_PAIR2, REG_PAIR3: begin
        shadow_cfg.pairs[idx - REG_PAIR0] = data;
      end
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Sampled on the falling edge so that every update of the rising edge has settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_readings.size() != 0 || src_valid || expected_setpoints.size() != 0);
  endtask

  always @(posedge clk_i) begin : reading_driver
    reading_t next_rd;
    if (rst_ni) begin
      if (src_valid && in_ch.ready) begin
        expected_setpoints.push_back(predict_setpoint(shadow_cfg, src_time, src_sensor));
        readings_sent++;
      end
      if (!src_valid || in_ch.ready) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          next_rd = pending_readings.pop_front();
          src_valid <= 1'b1;
          src_time <= next_rd.time_ms;
          src_sensor <= next_rd.sensor_temp;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : setpoint_monitor
    setpoint_t want;
    if (rst_ni) begin
      if (out_ch.valid && sink_ready) begin
        if (expected_setpoints.size() == 0) begin
          $error("result item with no reading pending: target_temp %0d", out_ch.target_temp);
          errors++;
        end else begin
          want = expected_setpoints.pop_front();
          if (out_ch.target_temp !== want.target_temp) begin
            $error("target_temp: expected %0d, got %0d", want.target_temp, out_ch.target_temp);
            errors++;
          end
          if (out_ch.pwm_percent !== want.pwm_percent) begin
            $error("pwm_percent: expected %0d, got %0d", want.pwm_percent, out_ch.pwm_percent);
            errors++;
          end
          if (out_ch.cooling_on !== want.cooling_on) begin
            $error("cooling_on: expected %0b, got %0b", want.cooling_on, out_ch.cooling_on);
            errors++;
          end
          if (out_ch.relay_on !== want.relay_on) begin
            $error("relay_on: expected %0b, got %0b", want.relay_on, out_ch.relay_on);
            errors++;
          end
          results_checked++;
          if (want.pwm_percent == PWM_HEAT) heat_results++;
          if (want.relay_on) relay_results++;
        end
      end
      sink_ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // One long stretch where the receiver refuses results so the block backs up.
  initial begin
    wait (hold_request);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin
    for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
      @(posedge clk_i);
    $display("reflow_profile_setpoint_controller: mismatch");
    $finish;
  end

  initial begin
    int setting, i, p, roll;
    logic [FIELD_W-1:0] fields[PHASE_MAX];
    logic [DEG_W-1:0] deg;
    logic [SEC_W-1:0] sec;
    logic [PAIR_W-1:0] junk;

    shadow_cfg.mode = 1'b1;
    shadow_cfg.const_target = 9'd20;
    shadow_cfg.phase_count = '0;
    shadow_cfg.pairs = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: ramping with no phases, so the start temperature holds.
    queue_reading('0, -14'sd8192);
    queue_reading(T_MAX, 14'sd8191);
    queue_reading(25'd1000, 14'sd287);
    queue_reading(25'd1000, 14'sd288);
    queue_reading(25'd5, -14'sd800);

    wait_drained();
    write_reg(REG_MODE, '0);
    write_reg(REG_CONST, 42'd511);
    close_writes();
    queue_reading('0, 14'sd8191);
    queue_reading(T_MAX, 14'sd8143);

    wait_drained();
    write_reg(REG_CONST, '0);
    close_writes();
    queue_reading(25'd7, -14'sd33);
    queue_reading(25'd7, -14'sd32);

    // An oversized phase count, a zero-length phase and an ignored register write.
    wait_drained();
    write_reg(REG_MODE, 42'd1);
    write_reg(REG_COUNT, 42'd15);
    write_reg(REG_PAIR0, {phase_bits(9'd0, 12'd0), phase_bits(9'd511, 12'd2)});
    write_reg(REG_PAIR1, {phase_bits(9'd100, 12'd1), phase_bits(9'd0, 12'd3)});
    write_reg(REG_PAIR2, {phase_bits(9'd511, 12'd4095), phase_bits(9'd511, 12'd4095)});
    write_reg(REG_PAIR3, {phase_bits(9'd20, 12'd1), phase_bits(9'd300, 12'd1)});
    write_reg(REG_UNUSED, '1);
    close_writes();
    queue_near_threshold('0);
    queue_near_threshold(25'd1);
    queue_near_threshold(25'd2000);
    queue_near_threshold(25'd2001);
    queue_near_threshold(25'd5000);
    queue_near_threshold(25'd5001);
    queue_near_threshold(25'd8197999);
    queue_near_threshold(25'd8198000);
    queue_near_threshold(T_MAX);

    // Every phase at its longest and hottest.
    wait_drained();
    write_reg(REG_COUNT, 42'd8);
    write_reg(REG_PAIR0, '1);
    write_reg(REG_PAIR1, '1);
    write_reg(REG_PAIR2, '1);
    write_reg(REG_PAIR3, '1);
    close_writes();
    queue_reading(25'd32760000, -14'sd800);
    queue_reading(25'd32759999, 14'sd8191);

    for (setting = 0; setting < 21; setting++) begin
      wait_drained();
      case (setting % 5)
        1: begin src_gap_pct = 46; sink_stall_pct = 0; end
        2: begin src_gap_pct = 0; sink_stall_pct = 46; end
        3: begin src_gap_pct = 7; sink_stall_pct = 7; end
        default: begin src_gap_pct = 0; sink_stall_pct = 0; end
      endcase

      // Upper data bits carry junk that the narrow registers must drop.
      junk = PAIR_W'({$urandom(), $urandom()});
      junk[0] = (setting % 7 == 2) ? 1'b0 : ($urandom_range(99) >= 10);
      write_reg(REG_MODE, junk);
      junk = PAIR_W'({$urandom(), $urandom()});
      roll = $urandom_range(99);
      if (roll < 10) junk[DEG_W-1:0] = '0;
      else if (roll < 20) junk[DEG_W-1:0] = '1;
      write_reg(REG_CONST, junk);
      junk = PAIR_W'({$urandom(), $urandom()});
      roll = $urandom_range(99);
      if (roll < 10) junk[3:0] = 4'd0;
      else if (roll < 20) junk[3:0] = 4'($urandom_range(15, 9));
      else junk[3:0] = 4'($urandom_range(8, 1));
      write_reg(REG_COUNT, junk);

      for (i = 0; i < PHASE_MAX; i++) begin
        roll = $urandom_range(99);
        if (roll < 10) deg = '0;
        else if (roll < 20) deg = '1;
        else deg = DEG_W'($urandom_range(511));
        roll = $urandom_range(99);
        if (roll < 10) sec = '0;
        else if (roll < 80) sec = SEC_W'($urandom_range(30, 1));
        else sec = SEC_W'($urandom_range(4095, 31));
        fields[i] = phase_bits(deg, sec);
      end
      for (p = 0; p < PAIRS; p++)
        write_reg(CFG_IDX_W'(REG_PAIR0 + p), {fields[2*p+1], fields[2*p]});
      if (setting % 5 == 4) write_reg(REG_UNUSED, PAIR_W'({$urandom(), $urandom()}));
      close_writes();

      if (setting == 3) hold_request = 1'b1;
      for (i = 0; i < 50; i++) begin
        // Halfway through one setting the sender waits for every result.
        if (setting == 6 && i == 25) wait_drained();
        queue_near_threshold(pick_time(shadow_cfg));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_setpoints.size() != 0) begin
      $error("%0d result items never arrived", expected_setpoints.size());
      errors++;
    end

    $display("Covered %0d readings across %0d register settings, constant and ramping.",
             readings_sent, settings_applied);
    $display("Checked %0d results: %0d with the heater on, %0d with the relay on.",
             results_checked, heat_results, relay_results);
    if (errors == 0) begin
      $display("reflow_profile_setpoint_controller: match");
    end else begin
      $display("reflow_profile_setpoint_controller: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rpsc_pkg.sv
rtl/rpsc_in_if.sv
rtl/rpsc_out_if.sv
rtl/rpsc_cfg.sv
rtl/rpsc_ctrl.sv
rtl/rpsc_dp.sv
rtl/reflow_profile_setpoint_controller.sv
sim/tb_reflow_profile_setpoint_controller.sv
